// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ilt_pkg.sv =====
// ---------------------------------------------------------------------------
// ilt_pkg
// Types, codes and constants shared by the INI line tokenizer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

   // Line buffer size default and the bound that caps result words per line
   localparam int LINE_BYTES_DEF = 32;
   localparam int MAX_RESULTS    = 32;

   // Positions within a line; six bits cover the full line size range
   localparam int POS_W   = 6;
   localparam int COMMA_W = 6;
   localparam logic [COMMA_W-1:0] COMMA_MAX = '1;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Characters of interest
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_FF       = 8'hFF;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;

   // Result kinds
   localparam logic [1:0] KIND_SECTION = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // End status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SECT  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_SECTION,
      JOB_KEYVAL
   } job_mode_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SECT,
      B_KEY,
      B_VAL,
      B_STAT
   } back_state_type;

   // One closed line (and optionally the end status) for the back part
   typedef struct packed {
      job_mode_type       mode;
      logic               bank;
      logic [POS_W-1:0]   key_len;
      logic [POS_W-1:0]   val_start;
      logic [POS_W-1:0]   line_len;
      logic [COMMA_W-1:0] commas;
      logic               has_end;
      logic [1:0]         status;
   } job_type;

   // Back part hands a line bank back to the front
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

`default_nettype wire

// ===== rtl/core/ini_line_tokenizer.sv =====
// ---------------------------------------------------------------------------
// ini_line_tokenizer
// INI text tokenizer: emits section, key and value bytes and an end status.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    text_byte, end_of_text
//   rsp_     out        rsp_valid/stall    kind, out_byte, value_items, status, last
//
// The front takes one text byte per cycle while req_stall is low and writes it into
// one of two line banks of the RAM; a closed line that emits is queued as a job
// (two deep). The back reads the job's bank and gives one result word per cycle
// while rsp_stall is low. Before the first word it takes the job, reads the RAM
// and loads the output register, in that order.
// req_stall is high while the front's current bank is still being read out or
// the job queue is full; rsp_stall freezes the back and its RAM read.
// Reset clears all control state at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module ini_line_tokenizer #(
   parameter int LINE_BYTES = ilt_pkg::LINE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [5:0] rsp_value_items,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   import ilt_pkg::*;

   localparam int ADDR_W = $clog2(LINE_BYTES) + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   release_type       rel;
   job_type           push_job, head_job;
   logic              push, pop, q_full, head_valid;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   ilt_front #(
      .LINE_BYTES (LINE_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .req_stall       (req_stall),
      .rel             (rel),
      .q_full          (q_full),
      .push            (push),
      .push_job        (push_job),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data)
   );

   ilt_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   ilt_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ilt_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rel             (rel),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_value_items (rsp_value_items),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ilt_ram.sv =====
// ---------------------------------------------------------------------------
// ilt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word; hold it while reads are idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ilt_front.sv =====
// ---------------------------------------------------------------------------
// ilt_front
// Accepts text bytes, stores each line into a RAM bank and classifies it.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_front #(
   parameter int LINE_BYTES = ilt_pkg::LINE_BYTES_DEF,
   parameter int ADDR_W     = $clog2(LINE_BYTES) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_end_of_text,
   output logic                 req_stall,
   input  ilt_pkg::release_type rel,
   input  logic                 q_full,
   output logic                 push,
   output ilt_pkg::job_type     push_job,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [7:0]           wr_data
);

   import ilt_pkg::*;

   localparam int IDX_W = ADDR_W - 1;

   // Line state
   logic [POS_W-1:0]   fill_ff, fill_in;
   logic [POS_W-1:0]   vis_ff, vis_in;
   logic [POS_W-1:0]   eq_ff, eq_in;
   logic [POS_W-1:0]   keyvis_ff, keyvis_in;
   logic [POS_W-1:0]   vstart_ff, vstart_in;
   logic [COMMA_W-1:0] comma_ff, comma_in;
   logic               first_lb_ff, first_lb_in;
   logic               last_rb_ff, last_rb_in;
   logic               comment_ff, comment_in;
   logic               seen_ff, seen_in;
   logic               ovf_ff, ovf_in;
   logic               bank_ff, bank_in;
   logic [1:0]         busy_ff, busy_in;

   // State after the byte itself, before any close
   logic [POS_W-1:0]   p_fill, p_vis, p_eq, p_keyvis, p_vstart;
   logic [COMMA_W-1:0] p_comma;
   logic               p_first_lb, p_last_rb, p_comment, p_ovf;

   logic accept, do_store, do_close, ending, closing;
   logic is_visible, sect_shape, emit_sect, emit_kv, line_job, seen_after;
   logic [1:0] status_code;

   assign req_stall = busy_ff[bank_ff] | q_full;
   assign accept    = req_valid & ~req_stall;
   assign is_visible = req_text_byte > CH_SPACE;

   // Classify the word and fold it into the line state
   always_comb begin
      do_store = 1'b0;
      do_close = 1'b0;
      ending   = req_end_of_text;

      p_fill     = fill_ff;
      p_vis      = vis_ff;
      p_eq       = eq_ff;
      p_keyvis   = keyvis_ff;
      p_vstart   = vstart_ff;
      p_comma    = comma_ff;
      p_first_lb = first_lb_ff;
      p_last_rb  = last_rb_ff;
      p_comment  = comment_ff;
      p_ovf      = ovf_ff;

      if (ovf_ff) begin
         if (req_text_byte == CH_NUL || req_text_byte == CH_FF) begin
            ending = 1'b1;
         end
      end else if (comment_ff) begin
         if (req_text_byte == CH_NUL) begin
            ending = 1'b1;
         end else if (req_text_byte == CH_CR || req_text_byte == CH_LF) begin
            do_close = 1'b1;
         end
      end else if (req_text_byte == CH_NUL || req_text_byte == CH_FF) begin
         ending = 1'b1;
      end else if (req_text_byte == CH_CR || req_text_byte == CH_LF) begin
         do_close = 1'b1;
      end else if (req_text_byte == CH_SEMI) begin
         p_comment = 1'b1;
      end else if (!(fill_ff == '0 && !is_visible)) begin
         do_store = 1'b1;
      end

      // Store the byte: track visible end, first '=', commas and value start
      if (do_store) begin
         p_fill = fill_ff + 1'b1;
         if (is_visible) begin
            p_vis     = p_fill;
            p_last_rb = req_text_byte == CH_RBRACKET;
         end
         if (fill_ff == '0) begin
            p_first_lb = req_text_byte == CH_LBRACKET;
         end
         if (req_text_byte == CH_EQUALS && eq_ff == '0) begin
            p_eq     = p_fill;
            p_keyvis = vis_ff;
         end else if (req_text_byte == CH_COMMA && eq_ff != '0 && comma_ff != COMMA_MAX) begin
            p_comma = comma_ff + 1'b1;
         end
         if (eq_ff != '0 && is_visible && vstart_ff == '0) begin
            p_vstart = fill_ff;
         end
         // Full line: flag overflow and drop what was gathered
         if (p_fill == POS_W'(LINE_BYTES)) begin
            p_ovf      = 1'b1;
            p_fill     = '0;
            p_vis      = '0;
            p_eq       = '0;
            p_keyvis   = '0;
            p_vstart   = '0;
            p_comma    = '0;
            p_first_lb = 1'b0;
            p_last_rb  = 1'b0;
            p_comment  = 1'b0;
         end
      end

      // Decide what the closing line emits
      closing    = do_close | ending;
      sect_shape = p_first_lb & p_last_rb;
      emit_sect  = !p_ovf && p_vis != '0 && sect_shape && p_vis >= POS_W'(3);
      emit_kv    = !p_ovf && p_vis != '0 && !sect_shape && seen_ff && p_eq != '0
                   && p_keyvis != '0 && p_vstart != '0;
      line_job   = closing & (emit_sect | emit_kv);
      seen_after = seen_ff | (closing & emit_sect);

      if (p_ovf) begin
         status_code = ST_OVERFLOW;
      end else if (seen_after) begin
         status_code = ST_OK;
      end else begin
         status_code = ST_NO_SECT;
      end

      push_job.mode      = emit_sect ? JOB_SECTION : (emit_kv ? JOB_KEYVAL : JOB_NONE);
      if (!closing) begin
         push_job.mode = JOB_NONE;
      end
      push_job.bank      = bank_ff;
      push_job.key_len   = p_keyvis;
      push_job.val_start = p_vstart;
      push_job.line_len  = p_vis;
      push_job.commas    = p_comma;
      push_job.has_end   = ending;
      push_job.status    = status_code;

      push = accept & (ending | line_job);

      // Next state
      fill_in     = p_fill;
      vis_in      = p_vis;
      eq_in       = p_eq;
      keyvis_in   = p_keyvis;
      vstart_in   = p_vstart;
      comma_in    = p_comma;
      first_lb_in = p_first_lb;
      last_rb_in  = p_last_rb;
      comment_in  = p_comment;
      ovf_in      = p_ovf;
      seen_in     = seen_ff;
      bank_in     = line_job ? ~bank_ff : bank_ff;
      if (closing) begin
         fill_in     = '0;
         vis_in      = '0;
         eq_in       = '0;
         keyvis_in   = '0;
         vstart_in   = '0;
         comma_in    = '0;
         first_lb_in = 1'b0;
         last_rb_in  = 1'b0;
         comment_in  = 1'b0;
         seen_in     = seen_after;
      end
      if (ending) begin
         seen_in = 1'b0;
         ovf_in  = 1'b0;
      end

      // Bank ownership: set on a line job, clear on release from the back
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept && line_job) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   assign wr_en   = accept & do_store;
   assign wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
   assign wr_data = req_text_byte;

   // Advance the line state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         vis_ff      <= '0;
         eq_ff       <= '0;
         keyvis_ff   <= '0;
         vstart_ff   <= '0;
         comma_ff    <= '0;
         first_lb_ff <= 1'b0;
         last_rb_ff  <= 1'b0;
         comment_ff  <= 1'b0;
         seen_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         bank_ff     <= 1'b0;
         busy_ff     <= '0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            fill_ff     <= fill_in;
            vis_ff      <= vis_in;
            eq_ff       <= eq_in;
            keyvis_ff   <= keyvis_in;
            vstart_ff   <= vstart_in;
            comma_ff    <= comma_in;
            first_lb_ff <= first_lb_in;
            last_rb_ff  <= last_rb_in;
            comment_ff  <= comment_in;
            seen_ff     <= seen_in;
            ovf_ff      <= ovf_in;
            bank_ff     <= bank_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ilt_job_queue.sv =====
// ---------------------------------------------------------------------------
// ilt_job_queue
// Short FIFO of line jobs between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ilt_pkg::job_type push_job,
   output logic             full,
   output logic             head_valid,
   output ilt_pkg::job_type head_job,
   input  logic             pop
);

   import ilt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold job words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ilt_back.sv =====
// ---------------------------------------------------------------------------
// ilt_back
// Walks each line job through the RAM and drives the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ilt_back #(
   parameter int ADDR_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  ilt_pkg::job_type     head_job,
   output logic                 pop,
   output ilt_pkg::release_type rel,
   output logic                 rd_en,
   output logic [ADDR_W-1:0]    rd_addr,
   input  logic [7:0]           rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_out_byte,
   output logic [5:0]           rsp_value_items,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);

   import ilt_pkg::*;

   localparam int IDX_W = ADDR_W - 1;
   localparam int CNT_W = $clog2(MAX_RESULTS);

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Read stage
   logic             s1_valid_ff;
   logic [1:0]       s1_kind_ff;
   logic [5:0]       s1_items_ff;
   logic [1:0]       s1_status_ff;
   logic             s1_last_ff;
   logic             s1_ram_ff;

   // Output register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [7:0]       rsp_byte_ff;
   logic [5:0]       rsp_items_ff;
   logic [1:0]       rsp_status_ff;
   logic             rsp_last_ff;

   logic       adv, cap_hit, line_end;
   logic       issue, iss_ram, iss_last;
   logic [1:0] iss_kind, iss_status;
   logic [5:0] iss_items;

   assign adv     = ~rsp_valid_ff | ~rsp_stall;
   assign cap_hit = cnt_ff == CNT_W'(MAX_RESULTS - 2);

   // Sequence one item per advancing cycle
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      pop        = 1'b0;
      rel.valid  = 1'b0;
      rel.bank   = job_ff.bank;
      issue      = 1'b0;
      iss_ram    = 1'b0;
      iss_kind   = KIND_END;
      iss_items  = '0;
      iss_status = ST_OK;
      iss_last   = 1'b0;
      line_end   = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (adv && head_valid) begin
               pop    = 1'b1;
               job_in = head_job;
               cnt_in = '0;
               case (head_job.mode)
                  JOB_SECTION: begin
                     state_in = B_SECT;
                     idx_in   = POS_W'(1);
                  end
                  JOB_KEYVAL: begin
                     state_in = B_KEY;
                     idx_in   = '0;
                  end
                  default: state_in = B_STAT;
               endcase
            end
         end
         B_SECT: begin
            if (adv) begin
               issue    = 1'b1;
               iss_ram  = 1'b1;
               iss_kind = KIND_SECTION;
               line_end = (idx_ff == job_ff.line_len - POS_W'(2)) | cap_hit;
               idx_in   = idx_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         B_KEY: begin
            if (adv) begin
               issue    = 1'b1;
               iss_ram  = 1'b1;
               iss_kind = KIND_KEY;
               line_end = cap_hit;
               cnt_in   = cnt_ff + 1'b1;
               if (idx_ff == job_ff.key_len - 1'b1) begin
                  state_in = B_VAL;
                  idx_in   = job_ff.val_start;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         B_VAL: begin
            if (adv) begin
               issue    = 1'b1;
               iss_ram  = 1'b1;
               iss_kind = KIND_VALUE;
               line_end = (idx_ff == job_ff.line_len - 1'b1) | cap_hit;
               if (idx_ff == job_ff.line_len - 1'b1) begin
                  iss_items = job_ff.commas + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_STAT: begin
            if (adv) begin
               issue      = 1'b1;
               iss_kind   = KIND_END;
               iss_status = job_ff.status;
               iss_last   = 1'b1;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase

      // Line finished: hand the bank back, then status or idle
      if (line_end) begin
         rel.valid = 1'b1;
         iss_last  = ~job_ff.has_end;
         state_in  = job_ff.has_end ? B_STAT : B_IDLE;
      end
   end

   assign rd_en   = issue & iss_ram;
   assign rd_addr = {job_ff.bank, idx_ff[IDX_W-1:0]};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers: advance only when the output can move
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (adv) begin
         s1_kind_ff    <= iss_kind;
         s1_items_ff   <= iss_items;
         s1_status_ff  <= iss_status;
         s1_last_ff    <= iss_last;
         s1_ram_ff     <= iss_ram;
         rsp_kind_ff   <= s1_kind_ff;
         rsp_byte_ff   <= s1_ram_ff ? rd_data : 8'h00;
         rsp_items_ff  <= s1_items_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_value_items = rsp_items_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   `ASSERT_IMPLIES(a_end_is_last, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_END, rsp_last_ff && rsp_byte_ff == 8'h00, "end status word not last or byte not zero")
   `ASSERT_IMPLIES(a_items_on_value, clock, reset, rsp_valid_ff && rsp_items_ff != 6'd0, rsp_kind_ff == KIND_VALUE, "item count on a non-value word")
   `ASSERT_IMPLIES(a_status_on_end, clock, reset, rsp_valid_ff && rsp_kind_ff != KIND_END, rsp_status_ff == ST_OK, "status set on a line word")
   `ASSERT_NEXT(a_pop_leaves_idle, clock, reset, pop, state_ff != B_IDLE, "sequencer idle after taking a job")

endmodule

`default_nettype wire
